>>> design/uer_pkg.sv
package uer_pkg;

  // Reset values of the configuration registers.
  localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd6000;
  localparam logic [15:0] SCALE_Q16_RESET     = 16'd11141;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_TIMEOUT_LIMIT = 1'b0,
    REG_SCALE_Q16     = 1'b1
  } cfg_reg_t;

  // One tick: sampled echo level and free-running timestamp.
  typedef struct packed {
    logic        echo_level;
    logic [31:0] timestamp;
  } in_item_t;

  // One result per tick.
  typedef struct packed {
    logic        trigger_out;
    logic        measuring;
    logic        distance_valid;
    logic [15:0] distance_cm;
  } out_item_t;

endpackage

>>> design/ultrasonic_echo_ranger_unit.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_item  (uer_pkg::in_item_t)
// out      output     out_valid / out_stall out_item (uer_pkg::out_item_t)
// cfg      input      cfg_write             cfg_index, cfg_data
//
// One item per cycle is accepted while in_stall is low; each tick passes the tick register, then the result register.
// The tick register feeds one pass of logic (a 32-bit subtract and a 32 x 16 multiply)
// into the result register, which sets the cycle time.
// Reset (rst, synchronous, active high) empties both registers and returns to idle.
// A stalled result holds; a new tick is still taken while the tick register is free.
module ultrasonic_echo_ranger_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  uer_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uer_pkg::out_item_t   out_item,
  input  logic                 cfg_write,
  input  logic [0:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers.
  logic [15:0] timeout_limit;
  logic [15:0] scale_q16;

  // Measurement state.
  logic        armed, armed_next;
  logic        trigger_phase, trigger_phase_next;
  logic        trigger_level, trigger_level_next;
  logic        echo_seen, echo_seen_next;
  logic [16:0] wait_count, wait_count_next;
  logic [31:0] start_stamp, start_stamp_next;
  logic [15:0] last_distance, last_distance_next;
  logic        distance_valid_next;

  // Pipeline registers.
  logic                s1_valid;
  uer_pkg::in_item_t   s1_item;
  logic                out_load;
  logic                advance;

  // Range arithmetic.
  logic [31:0] span;
  logic [47:0] product;
  logic [15:0] range_sat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= uer_pkg::TIMEOUT_LIMIT_RESET;
      scale_q16     <= uer_pkg::SCALE_Q16_RESET;
    end else if (cfg_write) begin
      unique case (uer_pkg::cfg_reg_t'(cfg_index))
        uer_pkg::REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        uer_pkg::REG_SCALE_Q16:     scale_q16     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the result register loads when empty or taken.
  assign out_load = !out_valid || !out_stall;
  assign advance  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;

  // Tick register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  // Distance from the echo pulse width, saturated to 16 bits.
  assign span      = s1_item.timestamp - start_stamp;
  assign product   = {16'd0, span} * {32'd0, scale_q16};
  assign range_sat = (|product[47:32]) ? 16'hFFFF : product[31:16];

  // Trigger step, then check step, for the tick in the tick register.
  always_comb begin
    armed_next          = armed;
    trigger_phase_next  = trigger_phase;
    trigger_level_next  = trigger_level;
    echo_seen_next      = echo_seen;
    wait_count_next     = wait_count;
    start_stamp_next    = start_stamp;
    last_distance_next  = last_distance;
    distance_valid_next = 1'b0;

    // Trigger pulse: high on the first idle tick, low and armed on the second.
    if (!armed) begin
      if (!trigger_phase) begin
        trigger_phase_next = 1'b1;
        trigger_level_next = 1'b1;
      end else begin
        trigger_phase_next = 1'b0;
        trigger_level_next = 1'b0;
        armed_next         = 1'b1;
      end
    end

    if (armed_next) begin
      // Wait for the echo to rise, giving up past the limit.
      if (!echo_seen) begin
        wait_count_next = wait_count + 17'd1;
      end else begin
        wait_count_next = 17'd0;
      end
      if (!echo_seen && (wait_count_next > {1'b0, timeout_limit})) begin
        wait_count_next = 17'd0;
        armed_next      = 1'b0;
      end else if (s1_item.echo_level && !echo_seen) begin
        start_stamp_next = s1_item.timestamp;
        echo_seen_next   = 1'b1;
      end else if (!s1_item.echo_level && echo_seen) begin
        last_distance_next  = range_sat;
        distance_valid_next = 1'b1;
        armed_next          = 1'b0;
        echo_seen_next      = 1'b0;
      end
    end
  end

  // State update as each tick moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      trigger_phase <= 1'b0;
      trigger_level <= 1'b0;
      echo_seen     <= 1'b0;
      wait_count    <= 17'd0;
      start_stamp   <= 32'd0;
      last_distance <= 16'd0;
    end else if (advance) begin
      armed         <= armed_next;
      trigger_phase <= trigger_phase_next;
      trigger_level <= trigger_level_next;
      echo_seen     <= echo_seen_next;
      wait_count    <= wait_count_next;
      start_stamp   <= start_stamp_next;
      last_distance <= last_distance_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      out_item.trigger_out    <= trigger_level_next;
      out_item.measuring      <= echo_seen_next;
      out_item.distance_valid <= distance_valid_next;
      out_item.distance_cm    <= last_distance_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Timing an echo only happens while armed.
  a_echo_needs_arm: assert property (@(posedge clk) disable iff (rst)
    echo_seen |-> armed)
    else $error("echo_seen set while not armed");

  // The wait counter is always cleared on the way back to idle.
  a_idle_wait_clear: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (wait_count == 17'd0))
    else $error("wait_count nonzero while idle");

  // A completed distance ends the measurement with the trigger low.
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.distance_valid) |-> (!out_item.measuring && !out_item.trigger_out))
    else $error("distance_valid with measuring or trigger high");
`endif

endmodule
